FILE: rtl/ils_pkg.sv
// ----------------------------------------------------------------------------
// ils_pkg: shared definitions for the indexed list store
// Field widths, request function codes, status codes and the command that the
// controller broadcasts to the row of storage cells.
// ----------------------------------------------------------------------------
package ils_pkg;

   // Default sizing of the store
   localparam int DEPTH_DEFAULT     = 64;
   localparam int WORD_BITS_DEFAULT = 32;

   // Fixed payload widths
   localparam int FUNC_BITS     = 2;
   localparam int POSITION_BITS = 7;
   localparam int DATA_BITS     = 32;
   localparam int LENGTH_BITS   = 7;
   localparam int STATUS_BITS   = 2;

   // Request function codes
   localparam logic [FUNC_BITS-1:0] FUNC_INSERT    = 2'd0;
   localparam logic [FUNC_BITS-1:0] FUNC_DELETE    = 2'd1;
   localparam logic [FUNC_BITS-1:0] FUNC_READ      = 2'd2;
   localparam logic [FUNC_BITS-1:0] FUNC_OVERWRITE = 2'd3;

   // Result status codes
   localparam logic [STATUS_BITS-1:0] STATUS_DONE  = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_RANGE = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_FULL  = 2'd2;

   // Command broadcast to every cell; at most one flag is set
   typedef struct packed {
      logic insert;     // open a slot at position, shift later entries up
      logic remove;     // drop the entry at position, shift later entries down
      logic overwrite;  // replace the entry at position
      logic read;       // present the entry at position on the tap
   } cell_cmd_type;

endpackage

FILE: rtl/ils_req_if.sv
// ----------------------------------------------------------------------------
// ils_req_if: request channel of the indexed list store
// Valid/ready handshake carrying function code, position and data word.
// ----------------------------------------------------------------------------
interface ils_req_if;

   logic                                valid;
   logic                                ready;
   logic [ils_pkg::FUNC_BITS-1:0]       func;
   logic [ils_pkg::POSITION_BITS-1:0]   position;
   logic [ils_pkg::DATA_BITS-1:0]       write_word;

   modport source (output valid, output func, output position, output write_word,
                   input ready);
   modport sink   (input valid, input func, input position, input write_word,
                   output ready);

endinterface

FILE: rtl/ils_rsp_if.sv
// ----------------------------------------------------------------------------
// ils_rsp_if: response channel of the indexed list store
// Valid/ready handshake carrying read word, list length and status.
// ----------------------------------------------------------------------------
interface ils_rsp_if;

   logic                                valid;
   logic                                ready;
   logic [ils_pkg::DATA_BITS-1:0]       read_word;
   logic [ils_pkg::LENGTH_BITS-1:0]     list_length;
   logic [ils_pkg::STATUS_BITS-1:0]     status;

   modport source (output valid, output read_word, output list_length, output status,
                   input ready);
   modport sink   (input valid, input read_word, input list_length, input status,
                   output ready);

endinterface

FILE: rtl/indexed_list_store_unit.sv
// ----------------------------------------------------------------------------
// indexed_list_store_unit: ordered list store with positional access
// An accepted request goes to the pending stage, its response to the response
// register. No request is taken while one is pending or a response waits untaken;
// the read tap of the cell row is collected in the cycle after the cells act.
// Insert and delete shift every later cell together.
// Reset: synchronous; clears the length and the handshake state, entries stay.
// ----------------------------------------------------------------------------
module indexed_list_store_unit #(
   parameter int DEPTH     = ils_pkg::DEPTH_DEFAULT,
   parameter int WORD_BITS = ils_pkg::WORD_BITS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   ils_req_if.sink    req_if,
   ils_rsp_if.source  rsp_if
);

   localparam int CNT_BITS = $clog2(DEPTH + 1);
   localparam int CMP_BITS = (CNT_BITS > ils_pkg::POSITION_BITS) ?
                             CNT_BITS : ils_pkg::POSITION_BITS;
   localparam logic [CNT_BITS-1:0] FULL_COUNT = CNT_BITS'(DEPTH);

   logic [CNT_BITS-1:0]              count_ff;
   logic [CNT_BITS-1:0]              count_in;
   logic                             pend_ff;
   logic [ils_pkg::LENGTH_BITS-1:0]  pend_length_ff;
   logic [ils_pkg::STATUS_BITS-1:0]  pend_status_ff;
   logic                             rsp_valid_ff;
   logic [ils_pkg::DATA_BITS-1:0]    rsp_word_ff;
   logic [ils_pkg::LENGTH_BITS-1:0]  rsp_length_ff;
   logic [ils_pkg::STATUS_BITS-1:0]  rsp_status_ff;

   logic                             req_ready;
   logic                             accept;
   logic [CMP_BITS-1:0]              pos_ext;
   logic [CMP_BITS-1:0]              cnt_ext;
   logic [ils_pkg::STATUS_BITS-1:0]  status;
   ils_pkg::cell_cmd_type            cmd;
   logic [WORD_BITS-1:0]             in_word;
   logic [WORD_BITS-1:0]             cell_word [DEPTH];
   logic [WORD_BITS-1:0]             cell_tap  [DEPTH];
   logic [WORD_BITS-1:0]             tap_or;

   // Handshake: one request in flight, output register frees on take
   assign req_ready = !pend_ff && (!rsp_valid_ff || rsp_if.ready);
   assign accept    = req_if.valid && req_ready;

   assign pos_ext = CMP_BITS'(req_if.position);
   assign cnt_ext = CMP_BITS'(count_ff);
   assign in_word = WORD_BITS'(req_if.write_word);

   // Check the position against the length
   always_comb begin
      status = ils_pkg::STATUS_DONE;
      case (req_if.func)
         ils_pkg::FUNC_INSERT: begin
            if (pos_ext > cnt_ext) begin
               status = ils_pkg::STATUS_RANGE;
            end else if (count_ff == FULL_COUNT) begin
               status = ils_pkg::STATUS_FULL;
            end
         end
         default: begin
            if (pos_ext >= cnt_ext) begin
               status = ils_pkg::STATUS_RANGE;
            end
         end
      endcase
   end

   // Build the cell command; a flagged request leaves the store alone
   always_comb begin
      cmd      = '0;
      count_in = count_ff;
      if (accept && (status == ils_pkg::STATUS_DONE)) begin
         case (req_if.func)
            ils_pkg::FUNC_INSERT: begin
               cmd.insert = 1'b1;
               count_in   = count_ff + 1'b1;
            end
            ils_pkg::FUNC_DELETE: begin
               cmd.remove = 1'b1;
               count_in   = count_ff - 1'b1;
            end
            ils_pkg::FUNC_READ: begin
               cmd.read = 1'b1;
            end
            default: begin
               cmd.overwrite = 1'b1;
            end
         endcase
      end
   end

   // Row of cells, each linked to its two neighbors
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [WORD_BITS-1:0] lower_word;
      logic [WORD_BITS-1:0] upper_word;

      if (i == 0) begin : g_first
         assign lower_word = '0;
      end else begin : g_lower
         assign lower_word = cell_word[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign upper_word = '0;
      end else begin : g_upper
         assign upper_word = cell_word[i+1];
      end

      ils_cell #(
         .WORD_BITS  (WORD_BITS),
         .CMP_BITS   (CMP_BITS),
         .CELL_INDEX (i)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .position   (pos_ext),
         .write_word (in_word),
         .lower_word (lower_word),
         .upper_word (upper_word),
         .word_out   (cell_word[i]),
         .tap_word   (cell_tap[i])
      );
   end

   // Collect the read taps; at most one cell drives a nonzero word
   always_comb begin
      tap_or = '0;
      for (int i = 0; i < DEPTH; i++) begin
         tap_or = tap_or | cell_tap[i];
      end
   end

   // Advance length, pending stage and response register
   always_ff @(posedge clock) begin
      if (accept) begin
         pend_length_ff <= ils_pkg::LENGTH_BITS'(count_in);
         pend_status_ff <= status;
      end
      if (pend_ff) begin
         rsp_word_ff   <= ils_pkg::DATA_BITS'(tap_or);
         rsp_length_ff <= pend_length_ff;
         rsp_status_ff <= pend_status_ff;
      end
      if (reset) begin
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         pend_ff  <= accept;
         if (pend_ff) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign req_if.ready       = req_ready;
   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.read_word   = rsp_word_ff;
   assign rsp_if.list_length = rsp_length_ff;
   assign rsp_if.status      = rsp_status_ff;

   // Length never passes the store size
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("list length beyond store size");

   // A full report only comes from a full store
   a_full_only_when_full: assert property (@(posedge clock) disable iff (reset)
      (accept && (status == ils_pkg::STATUS_FULL)) |-> (count_ff == FULL_COUNT))
      else $error("full status with room left");

   // Length changes only on an accepted request
   a_count_stable: assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(count_ff))
      else $error("length changed without a request");

   // Every pending request reaches the response register
   a_pend_to_rsp: assert property (@(posedge clock) disable iff (reset)
      pend_ff |=> rsp_valid_ff)
      else $error("pending request lost");

   // A flagged request leaves the length unchanged
   a_flag_keeps_count: assert property (@(posedge clock) disable iff (reset)
      (accept && (status != ils_pkg::STATUS_DONE)) |=> $stable(count_ff))
      else $error("flagged request changed the length");

endmodule

FILE: rtl/ils_cell.sv
// ----------------------------------------------------------------------------
// ils_cell: one storage cell of the list row
// Holds one entry; on insert takes the word of its lower neighbor, on delete
// the word of its upper neighbor, and compares the broadcast position with its
// own index to write or to present its entry for a read.
// ----------------------------------------------------------------------------
module ils_cell #(
   parameter int WORD_BITS  = ils_pkg::WORD_BITS_DEFAULT,
   parameter int CMP_BITS   = ils_pkg::POSITION_BITS,
   parameter int CELL_INDEX = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  ils_pkg::cell_cmd_type cmd,
   input  logic [CMP_BITS-1:0]   position,
   input  logic [WORD_BITS-1:0]  write_word,
   input  logic [WORD_BITS-1:0]  lower_word,
   input  logic [WORD_BITS-1:0]  upper_word,
   output logic [WORD_BITS-1:0]  word_out,
   output logic [WORD_BITS-1:0]  tap_word
);

   localparam logic [CMP_BITS-1:0] MY_INDEX = CMP_BITS'(CELL_INDEX);

   logic [WORD_BITS-1:0] word_ff;
   logic [WORD_BITS-1:0] word_in;
   logic                 sel_ff;
   logic                 sel_in;
   logic                 at_pos;
   logic                 above_pos;

   assign at_pos    = (position == MY_INDEX);
   assign above_pos = (MY_INDEX > position);

   // Pick the next entry: shift, write or hold
   always_comb begin
      word_in = word_ff;
      if (cmd.insert) begin
         if (above_pos) begin
            word_in = lower_word;
         end else if (at_pos) begin
            word_in = write_word;
         end
      end else if (cmd.remove) begin
         if (above_pos || at_pos) begin
            word_in = upper_word;
         end
      end else if (cmd.overwrite && at_pos) begin
         word_in = write_word;
      end
   end

   assign sel_in = cmd.read && at_pos;

   // Hold entry and read select
   always_ff @(posedge clock) begin
      word_ff <= word_in;
      if (reset) begin
         sel_ff <= 1'b0;
      end else begin
         sel_ff <= sel_in;
      end
   end

   assign word_out = word_ff;
   assign tap_word = sel_ff ? word_ff : '0;

endmodule

FILE: verif/tb_indexed_list_store_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_indexed_list_store_unit: self-checking bench for the indexed list store
// Opens with a short table of directed requests on an empty and a small list,
// then runs random episodes that grow the list to full, drain it and mix all
// functions. A shadow list predicts the responses that typed rows do not give;
// responses are matched in order. Sender bursts and receiver stalls are random.
// ----------------------------------------------------------------------------
module tb_indexed_list_store_unit;

   localparam int DEPTH         = ils_pkg::DEPTH_DEFAULT;
   localparam int FUNC_BITS     = ils_pkg::FUNC_BITS;
   localparam int POSITION_BITS = ils_pkg::POSITION_BITS;
   localparam int DATA_BITS     = ils_pkg::DATA_BITS;
   localparam int LENGTH_BITS   = ils_pkg::LENGTH_BITS;
   localparam int STATUS_BITS   = ils_pkg::STATUS_BITS;
   localparam int RANDOM_ITEMS  = 930;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int DRAIN_CYCLES  = 8;

   // Random episode flavors
   localparam int EP_GROW   = 0;
   localparam int EP_SHRINK = 1;
   localparam int EP_MIXED  = 2;

   typedef struct packed {
      logic [DATA_BITS-1:0]   read_word;
      logic [LENGTH_BITS-1:0] list_length;
      logic [STATUS_BITS-1:0] status;
   } list_result_type;

   typedef struct packed {
      logic [FUNC_BITS-1:0]     func;
      logic [POSITION_BITS-1:0] position;
      logic [DATA_BITS-1:0]     word;
      logic                     typed;
      list_result_type          want;
   } probe_row_type;

   logic clock;
   logic reset;

   ils_req_if req_ch ();
   ils_rsp_if rsp_ch ();

   indexed_list_store_unit uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   // Shadow copy of the list
   logic [DATA_BITS-1:0] shadow_words [DEPTH];
   int                   shadow_length;

   list_result_type pending_results [$];
   probe_row_type   opening_probes [$];

   int mismatch_count   = 0;
   int responses_seen   = 0;
   int requests_sent    = 0;
   int status_tally [3] = '{0, 0, 0};
   int peak_length      = 0;
   int cycle_count      = 0;
   int burst_left       = 0;

   // Receiver stall pattern state
   int stall_mode  = 0;
   int stall_left  = 0;
   int stall_phase = 0;
   int stall_period = 3;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Advance the shadow list by one request and return its response
   function automatic list_result_type apply_list_op(
                                          input logic [FUNC_BITS-1:0] func,
                                          input logic [POSITION_BITS-1:0] pos,
                                          input logic [DATA_BITS-1:0] word);
      list_result_type r;
      int              p;
      r = '0;
      p = int'(pos);
      case (func)
         ils_pkg::FUNC_INSERT: begin
            if (p > shadow_length) begin
               r.status = ils_pkg::STATUS_RANGE;
            end else if (shadow_length >= DEPTH) begin
               r.status = ils_pkg::STATUS_FULL;
            end else begin
               for (int i = shadow_length; i > p; i--) shadow_words[i] = shadow_words[i-1];
               shadow_words[p] = word;
               shadow_length++;
            end
         end
         ils_pkg::FUNC_DELETE: begin
            if (p >= shadow_length) begin
               r.status = ils_pkg::STATUS_RANGE;
            end else begin
               for (int i = p; i + 1 < shadow_length; i++) shadow_words[i] = shadow_words[i+1];
               shadow_length--;
            end
         end
         ils_pkg::FUNC_READ: begin
            if (p >= shadow_length) r.status = ils_pkg::STATUS_RANGE;
            else r.read_word = shadow_words[p];
         end
         default: begin
            if (p >= shadow_length) r.status = ils_pkg::STATUS_RANGE;
            else shadow_words[p] = word;
         end
      endcase
      r.list_length = LENGTH_BITS'(shadow_length);
      return r;
   endfunction

   // Present one request, hold it until accepted, then record its response
   task automatic send_request(input logic [FUNC_BITS-1:0] func,
                               input logic [POSITION_BITS-1:0] pos,
                               input logic [DATA_BITS-1:0] word,
                               input logic typed,
                               input list_result_type want);
      list_result_type predicted;
      req_ch.valid      <= 1'b1;
      req_ch.func       <= func;
      req_ch.position   <= pos;
      req_ch.write_word <= word;
      // Inputs only move at rising edges, so the falling edge sees settled ready
      @(negedge clock);
      while (!req_ch.ready) @(negedge clock);
      @(posedge clock);
      predicted = apply_list_op(func, pos, word);
      pending_results.push_back(typed ? want : predicted);
      requests_sent++;
      status_tally[predicted.status]++;
      if (shadow_length > peak_length) peak_length = shadow_length;
   endtask

   // Insert idle gaps between bursts of requests
   task automatic pace_sender();
      int gap;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(8, 1);
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(4) == 0) ? $urandom_range(80, 40) :
                                                 $urandom_range(24, 1);
      end
   endtask

   // Draw one random request biased by the episode flavor
   task automatic choose_request(input int flavor,
                                 output logic [FUNC_BITS-1:0] func,
                                 output logic [POSITION_BITS-1:0] pos,
                                 output logic [DATA_BITS-1:0] word);
      int roll;
      int top;
      roll = $urandom_range(99);
      case (flavor)
         EP_GROW:   func = roll < 60 ? ils_pkg::FUNC_INSERT : roll < 75 ? ils_pkg::FUNC_DELETE :
                           roll < 90 ? ils_pkg::FUNC_READ : ils_pkg::FUNC_OVERWRITE;
         EP_SHRINK: func = roll < 15 ? ils_pkg::FUNC_INSERT : roll < 75 ? ils_pkg::FUNC_DELETE :
                           roll < 90 ? ils_pkg::FUNC_READ : ils_pkg::FUNC_OVERWRITE;
         default:   func = FUNC_BITS'($urandom_range(3));
      endcase
      top  = (func == ils_pkg::FUNC_INSERT) ? shadow_length :
             (shadow_length > 0 ? shadow_length - 1 : 0);
      roll = $urandom_range(99);
      if (roll < 10) pos = POSITION_BITS'($urandom_range(127));
      else if (roll < 20) pos = POSITION_BITS'(shadow_length + $urandom_range(1));
      else if (roll < 28) pos = '0;
      else pos = POSITION_BITS'($urandom_range(top));
      // Probe the full store: insert at the end and one past it
      if (shadow_length == DEPTH && $urandom_range(2) == 0) begin
         func = ils_pkg::FUNC_INSERT;
         pos  = POSITION_BITS'(DEPTH + $urandom_range(1));
      end
      roll = $urandom_range(19);
      word = roll == 0 ? '0 : roll == 1 ? '1 : DATA_BITS'($urandom);
   endtask

   // Append one directed row; typed rows carry their own expected response
   task automatic add_probe(input logic [FUNC_BITS-1:0] func, input int pos,
                            input logic [DATA_BITS-1:0] word, input logic typed,
                            input logic [DATA_BITS-1:0] rd, input int len,
                            input logic [STATUS_BITS-1:0] st);
      probe_row_type row;
      row.func             = func;
      row.position         = POSITION_BITS'(pos);
      row.word             = word;
      row.typed            = typed;
      row.want.read_word   = rd;
      row.want.list_length = LENGTH_BITS'(len);
      row.want.status      = st;
      opening_probes.push_back(row);
   endtask

   task automatic report_field(input string label, input logic [DATA_BITS-1:0] want,
                               input logic [DATA_BITS-1:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h actual %h", $time, label, want, got);
         mismatch_count++;
      end
   endtask

   // Pick a new stall pattern now and then, drive ready from it
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode   <= $urandom_range(3);
         stall_left   <= $urandom_range(200, 20);
         stall_period <= $urandom_range(5, 2);
      end else begin
         stall_left <= stall_left - 1;
      end
      stall_phase <= stall_phase + 1;
      case (stall_mode)
         0:       rsp_ch.ready <= 1'b1;
         1:       rsp_ch.ready <= ($urandom_range(9) < 7);
         2:       rsp_ch.ready <= (stall_phase % stall_period == 0);
         default: rsp_ch.ready <= ($urandom_range(3) == 0);
      endcase
   end

   // Match each response against the oldest pending one
   always @(negedge clock) begin
      list_result_type want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready) begin
         responses_seen++;
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected response, expected none actual %h/%h/%h", $time,
                     rsp_ch.read_word, rsp_ch.list_length, rsp_ch.status);
            mismatch_count++;
         end else begin
            want = pending_results.pop_front();
            report_field("read_word", want.read_word, rsp_ch.read_word);
            report_field("list_length", DATA_BITS'(want.list_length),
                         DATA_BITS'(rsp_ch.list_length));
            report_field("status", DATA_BITS'(want.status), DATA_BITS'(rsp_ch.status));
         end
      end
   end

   // Guard against a hang
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: run stopped at cycle limit, %0d responses outstanding", $time,
                  pending_results.size());
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      logic [FUNC_BITS-1:0]     func;
      logic [POSITION_BITS-1:0] pos;
      logic [DATA_BITS-1:0]     word;
      int                       flavor;
      int                       episode_left;
      shadow_length     = 0;
      reset             = 1'b1;
      req_ch.valid      = 1'b0;
      req_ch.func       = ils_pkg::FUNC_READ;
      req_ch.position   = '0;
      req_ch.write_word = '0;
      rsp_ch.ready      = 1'b0;
      foreach (shadow_words[i]) shadow_words[i] = '0;

      // Directed requests: empty list, boundaries, shifts in both directions
      add_probe(ils_pkg::FUNC_READ,      0,   32'h0,        1, 32'h0,        0,
                ils_pkg::STATUS_RANGE);
      add_probe(ils_pkg::FUNC_DELETE,    0,   32'h0,        1, 32'h0,        0,
                ils_pkg::STATUS_RANGE);
      add_probe(ils_pkg::FUNC_OVERWRITE, 0,   32'hDEADBEEF, 1, 32'h0,        0,
                ils_pkg::STATUS_RANGE);
      add_probe(ils_pkg::FUNC_INSERT,    1,   32'h1,        1, 32'h0,        0,
                ils_pkg::STATUS_RANGE);
      add_probe(ils_pkg::FUNC_INSERT,    127, 32'hFFFFFFFF, 1, 32'h0,        0,
                ils_pkg::STATUS_RANGE);
      add_probe(ils_pkg::FUNC_INSERT,    0,   32'hFFFFFFFF, 1, 32'h0,        1,
                ils_pkg::STATUS_DONE);
      add_probe(ils_pkg::FUNC_INSERT,    1,   32'h0,        1, 32'h0,        2,
                ils_pkg::STATUS_DONE);
      add_probe(ils_pkg::FUNC_INSERT,    0,   32'hA5A5A5A5, 1, 32'h0,        3,
                ils_pkg::STATUS_DONE);
      add_probe(ils_pkg::FUNC_READ,      0,   32'h0,        1, 32'hA5A5A5A5, 3,
                ils_pkg::STATUS_DONE);
      add_probe(ils_pkg::FUNC_READ,      1,   32'h0,        1, 32'hFFFFFFFF, 3,
                ils_pkg::STATUS_DONE);
      add_probe(ils_pkg::FUNC_READ,      2,   32'hFFFFFFFF, 1, 32'h0,        3,
                ils_pkg::STATUS_DONE);
      add_probe(ils_pkg::FUNC_READ,      3,   32'h0,        1, 32'h0,        3,
                ils_pkg::STATUS_RANGE);
      add_probe(ils_pkg::FUNC_OVERWRITE, 1,   32'h5A5A5A5A, 1, 32'h0,        3,
                ils_pkg::STATUS_DONE);
      add_probe(ils_pkg::FUNC_OVERWRITE, 3,   32'h12345678, 1, 32'h0,        3,
                ils_pkg::STATUS_RANGE);
      add_probe(ils_pkg::FUNC_READ,      1,   32'h0,        1, 32'h5A5A5A5A, 3,
                ils_pkg::STATUS_DONE);
      add_probe(ils_pkg::FUNC_DELETE,    3,   32'h0,        1, 32'h0,        3,
                ils_pkg::STATUS_RANGE);
      add_probe(ils_pkg::FUNC_DELETE,    0,   32'h0,        1, 32'h0,        2,
                ils_pkg::STATUS_DONE);
      add_probe(ils_pkg::FUNC_INSERT,    1,   32'h12345678, 0, 32'h0,        0,
                ils_pkg::STATUS_DONE);
      add_probe(ils_pkg::FUNC_READ,      1,   32'h0,        0, 32'h0,        0,
                ils_pkg::STATUS_DONE);
      add_probe(ils_pkg::FUNC_DELETE,    2,   32'h0,        1, 32'h0,        2,
                ils_pkg::STATUS_DONE);
      add_probe(ils_pkg::FUNC_READ,      1,   32'h0,        0, 32'h0,        0,
                ils_pkg::STATUS_DONE);
      add_probe(ils_pkg::FUNC_INSERT,    2,   32'h80000001, 0, 32'h0,        0,
                ils_pkg::STATUS_DONE);
      add_probe(ils_pkg::FUNC_READ,      2,   32'h0,        0, 32'h0,        0,
                ils_pkg::STATUS_DONE);

      // Hold reset, then release it
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (opening_probes[i]) begin
         send_request(opening_probes[i].func, opening_probes[i].position,
                      opening_probes[i].word, opening_probes[i].typed,
                      opening_probes[i].want);
         pace_sender();
      end

      // Random episodes; the first one fills the list to probe the full store
      flavor       = EP_GROW;
      episode_left = 250;
      repeat (RANDOM_ITEMS) begin
         if (episode_left == 0) begin
            flavor       = $urandom_range(2);
            episode_left = $urandom_range(200, 40);
         end
         episode_left--;
         choose_request(flavor, func, pos, word);
         send_request(func, pos, word, 1'b0, '0);
         pace_sender();
      end
      req_ch.valid <= 1'b0;

      // Drain outstanding responses, then watch for strays
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d requests: %0d done, %0d out of range, %0d on a full list;",
               requests_sent, status_tally[ils_pkg::STATUS_DONE],
               status_tally[ils_pkg::STATUS_RANGE], status_tally[ils_pkg::STATUS_FULL]);
      $display("Peak length %0d; checked %0d responses with %0d mismatches.",
               peak_length, responses_seen, mismatch_count);
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

FILE: indexed_list_store_unit.f
rtl/ils_pkg.sv
rtl/ils_req_if.sv
rtl/ils_rsp_if.sv
rtl/ils_cell.sv
rtl/indexed_list_store_unit.sv
verif/tb_indexed_list_store_unit.sv
